@@ src/pgmap_pkg.sv @@
// ----------------------------------------------------------------------------
// pgmap_pkg
// Shared types and constants of the four-level page table mapper: request and
// result layouts, entry field positions and walk level codes.
// ----------------------------------------------------------------------------
package pgmap_pkg;

  // field widths
  localparam int unsigned VaW     = 48;
  localparam int unsigned PaW     = 52;
  localparam int unsigned FlagW   = 12;
  localparam int unsigned EntryW  = 64;
  localparam int unsigned FrameW  = 40;
  localparam int unsigned IdxW    = 9;
  localparam int unsigned UsedW   = 7;
  localparam int unsigned LevelW  = 2;

  // entry layout
  localparam int unsigned FrameLo = 12;
  localparam int unsigned FrameHi = 51;
  localparam int unsigned Present = 0;

  // walk levels, root first
  localparam logic [LevelW-1:0] LVL_ROOT = 2'd3;
  localparam logic [LevelW-1:0] LVL_DIR  = 2'd2;
  localparam logic [LevelW-1:0] LVL_MID  = 2'd1;
  localparam logic [LevelW-1:0] LVL_LEAF = 2'd0;

  // one mapping request
  typedef struct packed {
    logic [VaW-1:0]   virtual_address;
    logic [PaW-1:0]   physical_address;
    logic [FlagW-1:0] entry_flags;
  } pgmap_in_t;

  // one mapping result
  typedef struct packed {
    logic              mapped_ok;
    logic [UsedW-1:0]  tables_used;
    logic [EntryW-1:0] leaf_entry;
  } pgmap_out_t;

endpackage

@@ src/pgmap_walker.sv @@
// ----------------------------------------------------------------------------
// pgmap_walker
// Table store memory with its walk sequencer: clears the store after reset,
// then walks up to four levels per request, allocating table pages on the way.
// ----------------------------------------------------------------------------
module pgmap_walker #(
  parameter int unsigned TABLE_PAGES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [pgmap_pkg::FrameW-1:0]      base_frame_i,
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  pgmap_pkg::pgmap_in_t              req_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output pgmap_pkg::pgmap_out_t             res_o
);
  import pgmap_pkg::*;

  localparam int unsigned PgW   = $clog2(TABLE_PAGES);
  localparam int unsigned CntW  = $clog2(TABLE_PAGES + 1);
  localparam int unsigned AddrW = PgW + IdxW;
  localparam int unsigned Depth = TABLE_PAGES * (2 ** IdxW);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic [AddrW-1:0]     clr_addr_q;
  logic [PgW-1:0]       table_q;
  logic [LevelW-1:0]    level_q;
  logic [CntW-1:0]      next_free_q;
  logic [FrameW-1:0]    alloc_frame_q;
  logic [VaW-1:0]       va_q;
  logic [FrameW-1:0]    pa_frame_q;
  logic [FlagW-1:0]     flags_q;
  logic                 ok_q;
  logic [EntryW-1:0]    leaf_q;

  // table store
  logic [EntryW-1:0]    mem [Depth];
  logic [EntryW-1:0]    rd_data_q;
  logic                 rd_en;
  logic [AddrW-1:0]     rd_addr;
  logic                 wr_en;
  logic [AddrW-1:0]     wr_addr;
  logic [EntryW-1:0]    wr_data;

  // walk datapath
  logic [IdxW-1:0]      idx;
  logic [FrameW-1:0]    rel_frame;
  logic                 rel_ok;
  logic                 present;
  logic                 pages_left;
  logic [FlagW-1:0]     new_flags;
  logic [EntryW-1:0]    upper_entry;
  logic [EntryW-1:0]    leaf_entry;
  logic [CntW+UsedW-1:0] used_ext;

  // index bits of the current level
  always_comb begin
    unique case (level_q)
      LVL_ROOT: idx = va_q[47:39];
      LVL_DIR:  idx = va_q[38:30];
      LVL_MID:  idx = va_q[29:21];
      default:  idx = va_q[20:12];
    endcase
  end

  // entry decode and rebuild
  assign present     = rd_data_q[Present];
  assign rel_frame   = rd_data_q[FrameHi:FrameLo] - base_frame_i;
  assign rel_ok      = rel_frame < FrameW'(TABLE_PAGES);
  assign pages_left  = next_free_q < CntW'(TABLE_PAGES);
  assign new_flags   = rd_data_q[FlagW-1:0] | flags_q;
  assign upper_entry = {rd_data_q[EntryW-1:FrameHi+1], alloc_frame_q, new_flags};
  assign leaf_entry  = {rd_data_q[EntryW-1:FrameHi+1], pa_frame_q, new_flags};

  // memory port control
  assign rd_en   = (state_q == ST_READ);
  assign rd_addr = {table_q, idx};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr;
    wr_data = leaf_entry;
    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_q;
        wr_data = '0;
      end
      ST_EVAL: begin
        if (level_q == LVL_LEAF) begin
          wr_en = 1'b1;
        end else if (!present && pages_left) begin
          wr_en   = 1'b1;
          wr_data = upper_entry;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // store write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // store read port, registered output
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // walk sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_addr_q    <= '0;
      next_free_q   <= CntW'(1);
      table_q       <= '0;
      level_q       <= LVL_ROOT;
      ok_q          <= 1'b0;
      alloc_frame_q <= '0;
      va_q          <= '0;
      pa_frame_q    <= '0;
      flags_q       <= '0;
      leaf_q        <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_addr_q == AddrW'(Depth - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            clr_addr_q <= clr_addr_q + AddrW'(1);
          end
        end
        ST_IDLE: begin
          if (req_valid_i) begin
            va_q       <= req_i.virtual_address;
            pa_frame_q <= req_i.physical_address[FrameHi:FrameLo];
            flags_q    <= req_i.entry_flags;
            table_q    <= '0;
            level_q    <= LVL_ROOT;
            state_q    <= ST_READ;
          end
        end
        ST_READ: begin
          // frame of the page that would be allocated next
          alloc_frame_q <= base_frame_i + FrameW'(next_free_q);
          state_q       <= ST_EVAL;
        end
        ST_EVAL: begin
          if (level_q == LVL_LEAF) begin
            ok_q    <= 1'b1;
            leaf_q  <= leaf_entry;
            state_q <= ST_DONE;
          end else if (!present) begin
            if (pages_left) begin
              table_q     <= next_free_q[PgW-1:0];
              next_free_q <= next_free_q + CntW'(1);
              level_q     <= level_q - LevelW'(1);
              state_q     <= ST_READ;
            end else begin
              ok_q    <= 1'b0;
              leaf_q  <= '0;
              state_q <= ST_DONE;
            end
          end else if (rel_ok) begin
            table_q <= rel_frame[PgW-1:0];
            level_q <= level_q - LevelW'(1);
            state_q <= ST_READ;
          end else begin
            ok_q    <= 1'b0;
            leaf_q  <= '0;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // result
  assign used_ext             = {{UsedW{1'b0}}, next_free_q};
  assign req_ready_o          = (state_q == ST_IDLE);
  assign res_valid_o          = (state_q == ST_DONE);
  assign res_o.mapped_ok      = ok_q;
  assign res_o.tables_used    = used_ext[UsedW-1:0];
  assign res_o.leaf_entry     = leaf_q;

endmodule

@@ src/four_level_page_table_mapper.sv @@
// ----------------------------------------------------------------------------
// four_level_page_table_mapper
// Maps 48-bit virtual pages into a local four-level page table store.
// ----------------------------------------------------------------------------
// After reset the table store is swept to zero, one entry per cycle; no
// request is taken during that sweep, configuration writes are. Each request
// then walks the table levels, each in two steps (a registered memory read,
// then the check and write-back), four levels in a row, then hands the result
// on and returns to take the next request. A walk that fails at an upper
// level ends early. The result waits in an output register, so a new request
// is taken while the previous result is still pending.
module four_level_page_table_mapper #(
  parameter int unsigned TABLE_PAGES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pgmap_pkg::FrameW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pgmap_pkg::pgmap_in_t          in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pgmap_pkg::pgmap_out_t         out_res_o
);
  import pgmap_pkg::*;

  logic [FrameW-1:0] base_frame_q;
  logic              res_valid;
  logic              res_ready;
  pgmap_out_t        res;
  logic              out_valid_q;
  pgmap_out_t        out_res_q;

  // table base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_frame_q <= '0;
    end else if (cfg_we_i) begin
      base_frame_q <= cfg_wdata_i;
    end
  end

  // walker with table store
  pgmap_walker #(
    .TABLE_PAGES(TABLE_PAGES)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .base_frame_i (base_frame_q),
    .req_valid_i  (in_valid_i),
    .req_ready_o  (in_ready_o),
    .req_i        (in_req_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule
